// File: hdl/cfcb_pkg.sv
// shared types, constants and crc function for the command frame builder
package cfcb_pkg;

    localparam int MODE_W      = 3;
    localparam int ADDR_W      = 24;
    localparam int DATA_W      = 32;
    localparam int CODE_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 16;
    localparam int IDX_W       = 4;
    localparam int S_TDATA_W   = 64;

    localparam logic [MODE_W-1:0] MODE_REQUEST   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OPEN_LOCK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UPDATE    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERASE     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_INFO      = 3'd5;

    localparam logic [CODE_W-1:0] CODE_REQUEST   = 8'hC1;
    localparam logic [CODE_W-1:0] CODE_OPEN_LOCK = 8'hC3;
    localparam logic [CODE_W-1:0] CODE_UPDATE    = 8'hC5;
    localparam logic [CODE_W-1:0] CODE_FINISH    = 8'hC7;
    localparam logic [CODE_W-1:0] CODE_ERASE     = 8'hC9;
    localparam logic [CODE_W-1:0] CODE_INFO      = 8'hB1;

    localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'h41;
    localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'h43;

    // byte positions within the 13-byte frame
    localparam logic [IDX_W-1:0] IDX_HDR1    = 4'd1;
    localparam logic [IDX_W-1:0] IDX_HDR2    = 4'd2;
    localparam logic [IDX_W-1:0] IDX_PAY_END = 4'd10;
    localparam logic [IDX_W-1:0] IDX_CRC_LO  = 4'd11;
    localparam logic [IDX_W-1:0] IDX_CRC_HI  = 4'd12;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // command code in the low byte so it leaves the payload shifter first
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/cfcb_front.sv
// front end: takes commands, drops undefined modes, builds queue entries
module cfcb_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cfcb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output cfcb_pkg::entry_t               q_entry
);

    logic [cfcb_pkg::MODE_W-1:0] mode;
    logic [cfcb_pkg::ADDR_W-1:0] addr;
    logic [cfcb_pkg::DATA_W-1:0] data;
    logic                        mode_ok;
    logic                        carries_payload;

    assign mode = s_tdata[cfcb_pkg::MODE_W-1:0];
    assign addr = s_tdata[cfcb_pkg::MODE_W +: cfcb_pkg::ADDR_W];
    assign data = s_tdata[cfcb_pkg::MODE_W + cfcb_pkg::ADDR_W +: cfcb_pkg::DATA_W];

    always_comb begin
        mode_ok         = 1'b1;
        carries_payload = 1'b0;
        q_entry.code    = cfcb_pkg::CODE_REQUEST;
        unique case (mode)
            cfcb_pkg::MODE_REQUEST:   q_entry.code = cfcb_pkg::CODE_REQUEST;
            cfcb_pkg::MODE_OPEN_LOCK: q_entry.code = cfcb_pkg::CODE_OPEN_LOCK;
            cfcb_pkg::MODE_UPDATE: begin
                q_entry.code    = cfcb_pkg::CODE_UPDATE;
                carries_payload = 1'b1;
            end
            cfcb_pkg::MODE_FINISH: begin
                q_entry.code    = cfcb_pkg::CODE_FINISH;
                carries_payload = 1'b1;
            end
            cfcb_pkg::MODE_ERASE:     q_entry.code = cfcb_pkg::CODE_ERASE;
            cfcb_pkg::MODE_INFO:      q_entry.code = cfcb_pkg::CODE_INFO;
            default:                  mode_ok      = 1'b0;
        endcase
        q_entry.addr = carries_payload ? addr : '0;
        q_entry.data = carries_payload ? data : '0;
    end

    // undefined modes are accepted and dropped
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && mode_ok;

endmodule

// File: hdl/cfcb_queue.sv
// short fifo of classified commands between front and back
module cfcb_queue #(
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cfcb_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output cfcb_pkg::entry_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfcb_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

endmodule

// File: hdl/cfcb_back.sv
// back end: serializes one frame per entry and folds the crc in as bytes go out
module cfcb_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_not_empty,
    input  cfcb_pkg::entry_t            q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [cfcb_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast
);

    logic                          active_reg, active_next;
    logic [cfcb_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [cfcb_pkg::ENTRY_W-1:0]  pay_reg, pay_next;
    logic [cfcb_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          m_tlast_reg, m_tlast_next;
    logic [cfcb_pkg::BYTE_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                          advance;

    // output register is free or its byte is being taken
    assign advance = !m_tvalid_reg || m_tready;
    assign q_pop   = advance && !active_reg && q_not_empty;

    always_comb begin
        active_next   = active_reg;
        idx_next      = idx_reg;
        pay_next      = pay_reg;
        crc_next      = crc_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tlast_next  = m_tlast_reg;
        m_tdata_next  = m_tdata_reg;
        if (q_pop) begin
            active_next   = 1'b1;
            idx_next      = cfcb_pkg::IDX_HDR1;
            pay_next      = q_head;
            crc_next      = '0;
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b0;
            m_tdata_next  = cfcb_pkg::HDR_BYTE0;
        end else if (advance && active_reg) begin
            m_tvalid_next = 1'b1;
            idx_next      = idx_reg + 1'b1;
            priority if (idx_reg == cfcb_pkg::IDX_HDR1) begin
                m_tdata_next = cfcb_pkg::HDR_BYTE1;
            end else if (idx_reg == cfcb_pkg::IDX_HDR2) begin
                m_tdata_next = cfcb_pkg::HDR_BYTE2;
            end else if (idx_reg <= cfcb_pkg::IDX_PAY_END) begin
                m_tdata_next = pay_reg[cfcb_pkg::BYTE_W-1:0];
                pay_next     = pay_reg >> cfcb_pkg::BYTE_W;
                crc_next     = cfcb_pkg::crc16_byte(crc_reg, pay_reg[cfcb_pkg::BYTE_W-1:0]);
            end else if (idx_reg == cfcb_pkg::IDX_CRC_LO) begin
                m_tdata_next = crc_reg[cfcb_pkg::BYTE_W-1:0];
            end else begin
                m_tdata_next = crc_reg[cfcb_pkg::CRC_W-1:cfcb_pkg::BYTE_W];
                m_tlast_next = 1'b1;
                active_next  = 1'b0;
            end
        end else if (advance) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            active_reg   <= active_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        pay_reg     <= pay_next;
        crc_reg     <= crc_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = m_tdata_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (idx_reg <= cfcb_pkg::IDX_CRC_HI))
        else $error("frame byte index out of range");

    a_last_is_crc_hi: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tlast_reg)
            |-> (m_tdata_reg == crc_reg[cfcb_pkg::CRC_W-1:cfcb_pkg::BYTE_W]))
        else $error("last byte differs from crc high byte");

    a_last_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tlast_reg |-> !active_reg)
        else $error("frame still running after last byte");

    a_pop_starts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (active_reg && m_tvalid_reg && !m_tlast_reg
                   && (m_tdata_reg == cfcb_pkg::HDR_BYTE0)))
        else $error("new frame did not start with header");

endmodule

// File: hdl/command_frame_crc16_builder_top.sv
// top level of the crc16 command frame builder
//
//  channel | dir | tdata (low bit up)                          | tlast
//  s_      | in  | mode[2:0] address_bytes[26:3] data_word[58:27] | -
//  m_      | out | frame_byte[7:0]                             | last frame byte
//
// each command gives 13 bytes, one per cycle when m_tready stays high; the
// one-byte output register and serializer set that rate.
// undefined modes (6, 7) are taken and dropped with no output.
// reset clears the queue and serializer control; no clearing pass.
// a stalled output holds its byte; the front keeps taking commands until the
// queue of QUEUE_DEPTH entries fills.
module command_frame_crc16_builder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode[2:0], address_bytes[26:3], data_word[58:27], zero above
    input  logic [cfcb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // frame_byte[7:0]
    output logic [cfcb_pkg::BYTE_W-1:0]    m_tdata,
    output logic                           m_tlast
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_not_empty;
    cfcb_pkg::entry_t q_in;
    cfcb_pkg::entry_t q_head;

    cfcb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    cfcb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    cfcb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// File: tb/sv/command_frame_crc16_builder_top_test.sv
// testbench for the crc16 command frame builder: directed table, random commands, byte checks
module command_frame_crc16_builder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [cfcb_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [cfcb_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;
    localparam int FRAME_BYTES   = 13;
    localparam int CODE_POS      = 3;
    localparam int CRC_START     = 3;
    localparam int CRC_END       = 10;
    localparam int RANDOM_CMDS   = 360;
    localparam int STEADY_FIRST  = 150;
    localparam int STEADY_LAST   = 230;
    localparam int IDLE_PCT      = 38;
    localparam int DRAIN_CYCLES  = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DIRECTED_ROWS = 18;

    typedef struct packed {
        logic [cfcb_pkg::BYTE_W-1:0] frame_byte;
        logic                        last;
    } frame_beat_t;

    typedef struct packed {
        logic [cfcb_pkg::MODE_W-1:0] mode;
        logic [cfcb_pkg::ADDR_W-1:0] addr;
        logic [cfcb_pkg::DATA_W-1:0] data;
        logic                        typed;
        logic [cfcb_pkg::CODE_W-1:0] exp_code;
    } cmd_row_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [cfcb_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cfcb_pkg::BYTE_W-1:0]    m_tdata;
    logic                           m_tlast;

    frame_beat_t pending_beats[$];
    int          n_errors = 0;
    int          n_cycles = 0;
    bit          steady   = 1'b0;

    // typed rows carry the command code byte; undefined modes expect no frame at all
    cmd_row_t directed_rows[DIRECTED_ROWS] = '{
        '{cfcb_pkg::MODE_REQUEST,   24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_REQUEST},
        '{cfcb_pkg::MODE_OPEN_LOCK, 24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_OPEN_LOCK},
        '{cfcb_pkg::MODE_UPDATE,    24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_UPDATE},
        '{cfcb_pkg::MODE_FINISH,    24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_FINISH},
        '{cfcb_pkg::MODE_ERASE,     24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_ERASE},
        '{cfcb_pkg::MODE_INFO,      24'h000000, 32'h00000000, 1'b1, cfcb_pkg::CODE_INFO},
        '{cfcb_pkg::MODE_REQUEST,   24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_REQUEST},
        '{cfcb_pkg::MODE_OPEN_LOCK, 24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_OPEN_LOCK},
        '{cfcb_pkg::MODE_ERASE,     24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_ERASE},
        '{cfcb_pkg::MODE_INFO,      24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_INFO},
        '{cfcb_pkg::MODE_UPDATE,    24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_UPDATE},
        '{cfcb_pkg::MODE_FINISH,    24'hFFFFFF, 32'hFFFFFFFF, 1'b1, cfcb_pkg::CODE_FINISH},
        '{MODE_RSVD6,               24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'h00},
        '{MODE_RSVD7,               24'h000000, 32'h00000000, 1'b1, 8'h00},
        '{cfcb_pkg::MODE_UPDATE,    24'h123456, 32'h89ABCDEF, 1'b0, 8'h00},
        '{cfcb_pkg::MODE_FINISH,    24'h800001, 32'h80000001, 1'b0, 8'h00},
        '{MODE_RSVD7,               24'hFFFFFF, 32'hFFFFFFFF, 1'b1, 8'h00},
        '{cfcb_pkg::MODE_UPDATE,    24'h000080, 32'h01000000, 1'b0, 8'h00}
    };

    command_frame_crc16_builder_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [cfcb_pkg::CODE_W-1:0] command_code(
        input logic [cfcb_pkg::MODE_W-1:0] mode);
        case (mode)
            cfcb_pkg::MODE_REQUEST:   return cfcb_pkg::CODE_REQUEST;
            cfcb_pkg::MODE_OPEN_LOCK: return cfcb_pkg::CODE_OPEN_LOCK;
            cfcb_pkg::MODE_UPDATE:    return cfcb_pkg::CODE_UPDATE;
            cfcb_pkg::MODE_FINISH:    return cfcb_pkg::CODE_FINISH;
            cfcb_pkg::MODE_ERASE:     return cfcb_pkg::CODE_ERASE;
            default:                  return cfcb_pkg::CODE_INFO;
        endcase
    endfunction

    // serial lfsr form, one message bit per shift
    function automatic logic [cfcb_pkg::CRC_W-1:0] crc_shift_byte(
        input logic [cfcb_pkg::CRC_W-1:0]  crc,
        input logic [cfcb_pkg::BYTE_W-1:0] b);
        logic [cfcb_pkg::CRC_W-1:0] c;
        logic                       fb;
        c = crc;
        for (int i = cfcb_pkg::BYTE_W - 1; i >= 0; i--) begin
            fb = c[cfcb_pkg::CRC_W-1] ^ b[i];
            c  = {c[cfcb_pkg::CRC_W-2:0], 1'b0};
            if (fb) begin
                c = c ^ cfcb_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    // returns the number of frame bytes the command yields
    function automatic int build_frame(
        input logic [cfcb_pkg::MODE_W-1:0] mode,
        input logic [cfcb_pkg::ADDR_W-1:0] addr,
        input logic [cfcb_pkg::DATA_W-1:0] data,
        output logic [FRAME_BYTES-1:0][cfcb_pkg::BYTE_W-1:0] frame);
        logic [cfcb_pkg::CRC_W-1:0] crc;
        frame = '0;
        if (mode == MODE_RSVD6 || mode == MODE_RSVD7) begin
            return 0;
        end
        frame[0]        = cfcb_pkg::HDR_BYTE0;
        frame[1]        = cfcb_pkg::HDR_BYTE1;
        frame[2]        = cfcb_pkg::HDR_BYTE2;
        frame[CODE_POS] = command_code(mode);
        if (mode == cfcb_pkg::MODE_UPDATE || mode == cfcb_pkg::MODE_FINISH) begin
            for (int i = 0; i < 3; i++) begin
                frame[4 + i] = addr[8*i +: 8];
            end
            for (int i = 0; i < 4; i++) begin
                frame[7 + i] = data[8*i +: 8];
            end
        end
        crc = '0;
        for (int i = CRC_START; i <= CRC_END; i++) begin
            crc = crc_shift_byte(crc, frame[i]);
        end
        frame[11] = crc[7:0];
        frame[12] = crc[15:8];
        return FRAME_BYTES;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_command(input logic [cfcb_pkg::MODE_W-1:0] mode,
                                input logic [cfcb_pkg::ADDR_W-1:0] addr,
                                input logic [cfcb_pkg::DATA_W-1:0] data,
                                input logic                        typed,
                                input logic [cfcb_pkg::CODE_W-1:0] exp_code);
        logic [FRAME_BYTES-1:0][cfcb_pkg::BYTE_W-1:0] frame;
        int                                           n;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, data, addr, mode};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        n = build_frame(mode, addr, data, frame);
        if (typed && n != 0) begin
            frame[CODE_POS] = exp_code;
        end
        for (int i = 0; i < n; i++) begin
            pending_beats.push_back('{frame[i], i == FRAME_BYTES - 1});
        end
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        frame_beat_t exp_beat;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected transfer: frame_byte %h, last %b", m_tdata, m_tlast);
                n_errors++;
            end else begin
                exp_beat = pending_beats.pop_front();
                if (m_tdata !== exp_beat.frame_byte) begin
                    $error("frame_byte: expected %h, actual %h", exp_beat.frame_byte, m_tdata);
                    n_errors++;
                end
                if (m_tlast !== exp_beat.last) begin
                    $error("last: expected %b, actual %b", exp_beat.last, m_tlast);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [cfcb_pkg::MODE_W-1:0] mode;
        logic [cfcb_pkg::ADDR_W-1:0] addr;
        logic [cfcb_pkg::DATA_W-1:0] data;
        int                          n_sent;
        int                          sel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].mode, directed_rows[i].addr, directed_rows[i].data,
                         directed_rows[i].typed, directed_rows[i].exp_code);
        end

        n_sent = 0;
        while (n_sent < RANDOM_CMDS) begin
            steady = (n_sent >= STEADY_FIRST && n_sent < STEADY_LAST);
            // mostly defined commands, some undefined modes as noise
            if ($urandom_range(99) < 8) begin
                mode = $urandom_range(1) ? MODE_RSVD7 : MODE_RSVD6;
            end else begin
                mode = cfcb_pkg::MODE_W'($urandom_range(5));
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                addr = '0;
                data = '0;
            end else if (sel == 1) begin
                addr = '1;
                data = '1;
            end else begin
                addr = cfcb_pkg::ADDR_W'($urandom);
                data = $urandom;
            end
            send_command(mode, addr, data, 1'b0, 8'h00);
            if (mode != MODE_RSVD6 && mode != MODE_RSVD7) begin
                n_sent++;
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/cfcb_pkg.sv
hdl/cfcb_front.sv
hdl/cfcb_queue.sv
hdl/cfcb_back.sv
hdl/command_frame_crc16_builder_top.sv
tb/sv/command_frame_crc16_builder_top_test.sv
